@@ rtl/pct_pkg.sv @@
// parity count segment tree: shared types and constants
// used by the channel interfaces, the sequencer and the top level
`default_nettype none

package pct_pkg;

  localparam int IDX_W   = 10;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_EVEN = 2'd1,
    CMD_ODD  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/pct_if.sv @@
// valid/ready channel interfaces for command beats and count beats
// depends on pct_pkg
`default_nettype none

interface pct_in_if import pct_pkg::*; ();
  logic               valid;
  logic               ready;
  cmd_t               cmd;
  logic [IDX_W-1:0]   first_index;
  logic [IDX_W-1:0]   last_index;
  logic [VALUE_W-1:0] value;

  modport source (output valid, cmd, first_index, last_index, value, input ready);
  modport sink   (input valid, cmd, first_index, last_index, value, output ready);
endinterface

interface pct_out_if import pct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count;

  modport source (output valid, count, input ready);
  modport sink   (input valid, count, output ready);
endinterface

`default_nettype wire

@@ rtl/pct_mem.sv @@
// node count memory: one write port, one read port with registered data
// depends on pct_pkg
`default_nettype none

module pct_mem import pct_pkg::*; #(
  parameter int SIZE = 1024,
  localparam int AW = $clog2(2 * SIZE)
) (
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire logic [AW-1:0]      rd_addr,
  output logic      [COUNT_W-1:0] rd_data,
  input  wire logic               wr_en,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [COUNT_W-1:0] wr_data
);

  logic [COUNT_W-1:0] mem [2*SIZE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/pct_ctrl.sv @@
// sequencer for the tree: clearing sweep, leaf-to-root update walk and
// bottom-up range walk, all through the single node memory port pair
// depends on pct_pkg
`default_nettype none

module pct_ctrl import pct_pkg::*; #(
  parameter int SIZE = 1024,
  localparam int AW = $clog2(2 * SIZE)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cmd_t               cmd,
  input  wire logic [IDX_W-1:0]   first_index,
  input  wire logic [IDX_W-1:0]   last_index,
  input  wire logic               par_in,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic      [COUNT_W-1:0] res_count,
  output logic                    rd_en,
  output logic      [AW-1:0]      rd_addr,
  input  wire logic [COUNT_W-1:0] rd_data,
  output logic                    wr_en,
  output logic      [AW-1:0]      wr_addr,
  output logic      [COUNT_W-1:0] wr_data
);

  localparam int RW = $clog2(2 * SIZE + 1);
  localparam int EW = ((RW > IDX_W) ? RW : IDX_W) + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHK,
    ST_UP,
    ST_QL,
    ST_QR,
    ST_QEND,
    ST_DONE
  } state_t;

  state_t             state;
  logic [AW-1:0]      clr;
  logic [AW-1:0]      node;
  logic               par;
  logic [RW-1:0]      lq;
  logic [RW-1:0]      rq;
  logic               pend;
  logic               odd_mode;
  logic [COUNT_W-1:0] sum;
  logic [COUNT_W-1:0] len;

  logic [EW-1:0]      first_e;
  logic [EW-1:0]      last_e;
  logic [EW-1:0]      last_sat;
  logic [EW-1:0]      size_e;
  logic               set_ok;
  logic               range_empty;
  logic [AW-1:0]      leaf;
  logic [AW-1:0]      parent;
  logic [RW-1:0]      r_dec;
  logic [RW-1:0]      r_new;
  logic [COUNT_W-1:0] bump;
  logic               accept;

  always_comb begin
    size_e      = EW'(SIZE);
    first_e     = EW'(first_index);
    last_e      = EW'(last_index);
    last_sat    = (last_e >= size_e) ? size_e - EW'(1) : last_e;
    set_ok      = first_e < size_e;
    range_empty = (first_e > last_sat) || (first_e >= size_e);
    leaf        = AW'(first_e + size_e);
    parent      = node >> 1;
    r_dec       = rq - RW'(1);
    r_new       = rq[0] ? r_dec : rq;
    bump        = par ? rd_data + COUNT_W'(1) : rd_data - COUNT_W'(1);
    accept      = in_valid && in_ready;
  end

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res_count = odd_mode ? sum : len - sum;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr;
      end
      ST_IDLE: begin
        if (in_valid && cmd == CMD_SET && set_ok) begin
          rd_en   = 1'b1;
          rd_addr = leaf;
        end
      end
      ST_CHK: begin
        // leaf count is the stored parity
        if (rd_data[0] != par) begin
          wr_en   = 1'b1;
          wr_addr = node;
          wr_data = bump;
          rd_en   = 1'b1;
          rd_addr = parent;
        end
      end
      ST_UP: begin
        wr_en   = 1'b1;
        wr_addr = node;
        wr_data = bump;
        if (node != AW'(1)) begin
          rd_en   = 1'b1;
          rd_addr = parent;
        end
      end
      ST_QL: begin
        if (lq < rq && lq[0]) begin
          rd_en   = 1'b1;
          rd_addr = lq[AW-1:0];
        end
      end
      ST_QR: begin
        if (rq[0]) begin
          rd_en   = 1'b1;
          rd_addr = r_dec[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      pend  <= 1'b0;
    end else begin
      // a read issued last cycle lands in the running sum now
      pend <= 1'b0;
      if (pend) begin
        sum <= sum + rd_data;
      end
      case (state)
        ST_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(2 * SIZE - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            par      <= par_in;
            node     <= leaf;
            odd_mode <= (cmd == CMD_ODD);
            sum      <= '0;
            lq       <= RW'(first_e + size_e);
            rq       <= RW'(last_sat + size_e + EW'(1));
            len      <= COUNT_W'(last_sat - first_e + EW'(1));
            case (cmd)
              CMD_SET: begin
                if (set_ok) begin
                  state <= ST_CHK;
                end
              end
              CMD_EVEN, CMD_ODD: begin
                if (range_empty) begin
                  len   <= '0;
                  state <= ST_DONE;
                end else begin
                  state <= ST_QL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_CHK: begin
          if (rd_data[0] != par) begin
            node  <= parent;
            state <= ST_UP;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_UP: begin
          node <= parent;
          if (node == AW'(1)) begin
            state <= ST_IDLE;
          end
        end
        ST_QL: begin
          if (lq < rq) begin
            if (lq[0]) begin
              pend <= 1'b1;
              lq   <= lq + RW'(1);
            end
            state <= ST_QR;
          end else begin
            state <= ST_QEND;
          end
        end
        ST_QR: begin
          pend  <= rq[0];
          lq    <= lq >> 1;
          rq    <= r_new >> 1;
          state <= ST_QL;
        end
        ST_QEND: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/parity_count_segment_tree_unit.sv @@
// set: accept, leaf check, then one update per ancestor up to the root;
// back to idle after the leaf check when the parity does not change
// count: accept, a left and a right step per tree level, then a closing step and the
// result state; one command at a time, single read port
// the count beat sits in an output register, so the next command is taken meanwhile
// reset: synchronous, then a clearing sweep over all 2*SIZE node memory words, ready low
`default_nettype none

module parity_count_segment_tree_unit import pct_pkg::*; #(
  parameter int SIZE = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  pct_in_if.sink    req,
  pct_out_if.source rsp
);

  localparam int AW = $clog2(2 * SIZE);

  logic               res_valid;
  logic               res_ready;
  logic [COUNT_W-1:0] res_count;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [COUNT_W-1:0] rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;
  logic               out_valid;
  logic [COUNT_W-1:0] out_count;

  pct_ctrl #(.SIZE(SIZE)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .cmd         (req.cmd),
    .first_index (req.first_index),
    .last_index  (req.last_index),
    .par_in      (req.value[0]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_count   (res_count),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  pct_mem #(.SIZE(SIZE)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // output beat register
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
      out_count <= res_count;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.count = out_count;

endmodule

`default_nettype wire

@@ rtl/pct_check.sv @@
// port-level checks for parity_count_segment_tree_unit, attached by bind
// depends on pct_pkg and the top level
`default_nettype none

module pct_check import pct_pkg::*; #(
  parameter int SIZE = 1024
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire cmd_t               req_cmd,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic [COUNT_W-1:0] rsp_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count))
    else $error("count beat dropped or changed while stalled");

  a_clear_busy: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("ready during clearing sweep");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (SIZE >= 2048) || (int'(rsp_count) <= SIZE))
    else $error("count above store size");

  a_set_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_cmd == CMD_SET || req_cmd == CMD_NOP) && !rsp_valid
    |=> !rsp_valid)
    else $error("count beat after a set");

endmodule

bind parity_count_segment_tree_unit pct_check #(.SIZE(SIZE)) u_pct_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_cmd   (req.cmd),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_count (rsp.count)
);

`default_nettype wire
